// File: hdl/ked_pkg.sv
`default_nettype none

package ked_pkg;

    // key set and field widths
    localparam int NUM_KEYS   = 10;
    localparam int KEY_IDX_W  = 4;
    localparam int HOLD_W     = 15;
    localparam int THR_W      = 15;
    localparam int DC_W       = 16;
    localparam int REP_W      = 8;
    localparam int TIME_W     = 32;
    localparam int BTN_W      = 2;
    localparam int NUM_AXES   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [HOLD_W-1:0]    HOLD_MAX = {HOLD_W{1'b1}};
    localparam logic [KEY_IDX_W-1:0] KEY_LAST = KEY_IDX_W'(NUM_KEYS - 1);

    // register reset values
    localparam logic [THR_W-1:0]  PRESS_THR_RST = THR_W'(9830);
    localparam logic [THR_W-1:0]  HOLD_THR_RST  = THR_W'(6554);
    localparam logic [DC_W-1:0]   DC_MS_RST     = DC_W'(300);
    localparam logic [HOLD_W-1:0] LONG_RST      = HOLD_W'(30);
    localparam logic [REP_W-1:0]  REPEAT_RST    = REP_W'(10);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE    = 3'd0,
        CFG_PRESS_THR = 3'd1,
        CFG_HOLD_THR  = 3'd2,
        CFG_DC_MS     = 3'd3,
        CFG_LONG      = 3'd4,
        CFG_REPEAT    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_DOWN   = 2'd0,
        EV_DOUBLE = 2'd1,
        EV_HELD   = 2'd2,
        EV_UP     = 2'd3
    } t_event_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_DIR,
        ST_WALK,
        ST_REM,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [KEY_IDX_W-1:0] key_index;
        t_event_kind          event_kind;
        logic [HOLD_W-1:0]    hold_ticks;
        logic                 last_event;
    } t_event;

endpackage

`default_nettype wire

// File: hdl/ked_tick_if.sv
`default_nettype none

interface ked_tick_if #(
    parameter int AXIS_W = 16
);
    import ked_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [BTN_W-1:0]         button_bits;
    logic signed [AXIS_W-1:0] stick_a_x;
    logic signed [AXIS_W-1:0] stick_a_y;
    logic signed [AXIS_W-1:0] stick_b_x;
    logic signed [AXIS_W-1:0] stick_b_y;
    logic [TIME_W-1:0]        time_ms;

    modport source (
        output valid, button_bits, stick_a_x, stick_a_y, stick_b_x, stick_b_y, time_ms,
        input  ready
    );
    modport sink (
        input  valid, button_bits, stick_a_x, stick_a_y, stick_b_x, stick_b_y, time_ms,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/ked_event_if.sv
`default_nettype none

interface ked_event_if;
    import ked_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KEY_IDX_W-1:0] key_index;
    logic [1:0]           event_kind;
    logic [HOLD_W-1:0]    hold_ticks;
    logic                 last_event;

    modport source (
        output valid, key_index, event_kind, hold_ticks, last_event,
        input  ready
    );
    modport sink (
        input  valid, key_index, event_kind, hold_ticks, last_event,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/ked_rem.sv
`default_nettype none

module ked_rem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ked_pkg::HOLD_W-1:0] i_dividend,
    input  wire logic [ked_pkg::REP_W-1:0]  i_divisor,
    output logic                            o_valid,
    output logic [ked_pkg::REP_W-1:0]       o_rem
);
    import ked_pkg::*;

    localparam int STEP_W = $clog2(HOLD_W + 1);

    logic              r_busy;
    logic              r_valid;
    logic [STEP_W-1:0] r_step;
    logic [HOLD_W-1:0] r_dvd;
    logic [REP_W-1:0]  r_div;
    logic [REP_W-1:0]  r_rem;
    logic [REP_W:0]    w_trial;
    logic [REP_W:0]    w_diff;
    logic              w_fits;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        w_trial = {r_rem, r_dvd[HOLD_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_fits  = (w_trial >= {1'b0, r_div});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
            r_step  <= STEP_W'(HOLD_W - 1);
        end else if (r_busy) begin
            if (r_step == '0) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end else begin
                r_step <= r_step - 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[HOLD_W-2:0], 1'b0};
            r_rem <= w_fits ? w_diff[REP_W-1:0] : w_trial[REP_W-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;

endmodule

`default_nettype wire

// File: hdl/key_event_detector_core.sv
// channel   dir  handshake      payload
// i_tick    in   valid / ready  button_bits, stick_a_x/y, stick_b_x/y, time_ms
// o_event   out  valid / ready  key_index, event_kind, hold_ticks, last_event
// i_cfg_*   in   write enable   register index, write data
//
// a tick steps through capture, filter, key decode, one step per key and a closing one;
// a key that may fire a held press also waits for the shared remainder unit
// (one quotient bit per cycle); at most six keys are down at once, and the
// events leave through one pending register and one output register;
// a full output stalls the key walk, never the event order
// reset is synchronous; i_tick.ready is high only between ticks
`default_nettype none

module key_event_detector_core #(
    parameter int AXIS_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    ked_tick_if.sink                            i_tick,
    ked_event_if.source                         o_event,
    input  wire logic                           i_cfg_we,
    input  wire logic [ked_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ked_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ked_pkg::*;

    localparam int CMP_W = ((AXIS_WIDTH > THR_W) ? AXIS_WIDTH : THR_W) + 1;

    // configuration
    logic              r_enable;
    logic [THR_W-1:0]  r_press_thr;
    logic [THR_W-1:0]  r_hold_thr;
    logic [DC_W-1:0]   r_dc_ms;
    logic [HOLD_W-1:0] r_long;
    logic [REP_W-1:0]  r_rep;

    // tick state
    t_state                       r_state, n_state;
    logic [BTN_W-1:0]             r_in_btn;
    logic signed [AXIS_WIDTH-1:0] r_in_axis [NUM_AXES];
    logic [TIME_W-1:0]            r_time;
    logic signed [AXIS_WIDTH-1:0] r_axis [NUM_AXES];
    logic signed [AXIS_WIDTH-1:0] n_axis [NUM_AXES];
    logic [NUM_KEYS-1:0]          r_keys, n_keys;
    logic [KEY_IDX_W-1:0]         r_idx;
    logic [NUM_KEYS-1:0]          r_rel;
    logic [HOLD_W-1:0]            r_cnt [NUM_KEYS];
    logic [TIME_W-1:0]            r_ldt [NUM_KEYS];
    logic [HOLD_W-1:0]            r_rem_cnt;

    // event buffering
    t_event r_pend;
    logic   r_pend_v;
    t_event r_out;
    logic   r_out_v;

    // current key
    logic              w_pressed, w_rel, w_adv, w_dc, w_ev, w_need_rem;
    logic [HOLD_W-1:0] w_cnt, w_cnt_new, w_ev_cnt;
    logic [TIME_W-1:0] w_ldt;
    t_event_kind       w_ev_kind;
    logic              w_rem_valid;
    logic [REP_W-1:0]  w_rem;
    logic              w_can_post, w_out_free, w_accept;

    // sequencer strobes
    logic              s_load, s_filt, s_dir, s_upd, s_rem_start, s_post, s_next, s_flush;
    t_event_kind       w_post_kind;
    logic [HOLD_W-1:0] w_post_cnt;

    function automatic logic dir_hit(
        input logic                         held,
        input logic signed [AXIS_WIDTH-1:0] axis,
        input logic [THR_W-1:0]             press_thr,
        input logic [THR_W-1:0]             hold_thr,
        input logic                         positive
    );
        logic signed [CMP_W-1:0] a;
        logic signed [CMP_W-1:0] t;
        a = CMP_W'(axis);
        t = CMP_W'(held ? hold_thr : press_thr);
        return positive ? (a > t) : (a < -t);
    endfunction

    assign w_accept   = i_tick.valid && i_tick.ready;
    assign w_out_free = !r_out_v || o_event.ready;
    assign w_can_post = !r_pend_v || w_out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_press_thr <= PRESS_THR_RST;
            r_hold_thr  <= HOLD_THR_RST;
            r_dc_ms     <= DC_MS_RST;
            r_long      <= LONG_RST;
            r_rep       <= REPEAT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:    r_enable    <= i_cfg_data[0];
                CFG_PRESS_THR: r_press_thr <= i_cfg_data[THR_W-1:0];
                CFG_HOLD_THR:  r_hold_thr  <= i_cfg_data[THR_W-1:0];
                CFG_DC_MS:     r_dc_ms     <= i_cfg_data[DC_W-1:0];
                CFG_LONG:      r_long      <= i_cfg_data[HOLD_W-1:0];
                CFG_REPEAT:    r_rep       <= i_cfg_data[REP_W-1:0];
                default: ;
            endcase
        end
    end

    // axis averaging, floor of half the sum
    always_comb begin
        logic signed [AXIS_WIDTH:0] sum;
        for (int k = 0; k < NUM_AXES; k++) begin
            sum       = (AXIS_WIDTH+1)'(r_axis[k]) + (AXIS_WIDTH+1)'(r_in_axis[k]);
            n_axis[k] = sum[AXIS_WIDTH:1];
        end
    end

    // direction keys with hysteresis against the previous key status
    always_comb begin
        n_keys[BTN_W-1:0] = r_in_btn;
        for (int s = 0; s < 2; s++) begin
            n_keys[2+4*s] = dir_hit(r_keys[2+4*s], r_axis[2*s], r_press_thr, r_hold_thr, 1'b1);
            n_keys[3+4*s] = dir_hit(r_keys[3+4*s], r_axis[2*s+1], r_press_thr, r_hold_thr,
                                    1'b1);
            n_keys[4+4*s] = dir_hit(r_keys[4+4*s], r_axis[2*s], r_press_thr, r_hold_thr, 1'b0);
            n_keys[5+4*s] = dir_hit(r_keys[5+4*s], r_axis[2*s+1], r_press_thr, r_hold_thr,
                                    1'b0);
        end
    end

    // per key evaluation
    always_comb begin
        w_pressed  = r_keys[r_idx];
        w_rel      = r_rel[r_idx];
        w_cnt      = r_cnt[r_idx];
        w_ldt      = r_ldt[r_idx];
        w_adv      = w_rel || (w_cnt != HOLD_MAX);
        w_cnt_new  = w_rel ? '0 : (w_adv ? w_cnt + 1'b1 : w_cnt);
        w_dc       = (r_time - w_ldt) < TIME_W'(r_dc_ms);
        w_need_rem = w_pressed && w_adv && (w_cnt_new >= HOLD_W'(2)) && (r_rep != '0)
                     && (w_cnt_new >= r_long);
        w_ev       = w_pressed ? (w_cnt_new == HOLD_W'(1)) : (!w_rel && (w_cnt != '0));
        w_ev_kind  = w_pressed ? (w_dc ? EV_DOUBLE : EV_DOWN) : EV_UP;
        w_ev_cnt   = w_pressed ? w_cnt_new : w_cnt;
    end

    // sequencer next state and strobes
    always_comb begin
        n_state      = r_state;
        i_tick.ready = 1'b0;
        s_load       = 1'b0;
        s_filt       = 1'b0;
        s_dir        = 1'b0;
        s_upd        = 1'b0;
        s_rem_start  = 1'b0;
        s_post       = 1'b0;
        s_next       = 1'b0;
        s_flush      = 1'b0;
        w_post_kind  = w_ev_kind;
        w_post_cnt   = w_ev_cnt;
        case (r_state)
            ST_IDLE: begin
                i_tick.ready = 1'b1;
                if (i_tick.valid && r_enable) begin
                    s_load  = 1'b1;
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                s_filt  = 1'b1;
                n_state = ST_DIR;
            end
            ST_DIR: begin
                s_dir   = 1'b1;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (w_need_rem) begin
                    s_upd       = 1'b1;
                    s_rem_start = 1'b1;
                    n_state     = ST_REM;
                end else if (!w_ev || w_can_post) begin
                    s_upd   = 1'b1;
                    s_post  = w_ev;
                    s_next  = 1'b1;
                    n_state = (r_idx == KEY_LAST) ? ST_FLUSH : ST_WALK;
                end
            end
            ST_REM: begin
                w_post_kind = EV_HELD;
                w_post_cnt  = r_rem_cnt;
                if (w_rem_valid && ((w_rem != '0) || w_can_post)) begin
                    s_post  = (w_rem == '0);
                    s_next  = 1'b1;
                    n_state = (r_idx == KEY_LAST) ? ST_FLUSH : ST_WALK;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    s_flush = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // tick capture
    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_in_btn     <= i_tick.button_bits;
            r_in_axis[0] <= i_tick.stick_a_x;
            r_in_axis[1] <= i_tick.stick_a_y;
            r_in_axis[2] <= i_tick.stick_b_x;
            r_in_axis[3] <= i_tick.stick_b_y;
            r_time       <= i_tick.time_ms;
        end
        if (s_rem_start) begin
            r_rem_cnt <= w_cnt_new;
        end
    end

    // filter, key status and key walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_axis[k] <= '0;
            end
            r_keys <= '0;
            r_rel  <= '1;
            r_idx  <= '0;
            for (int j = 0; j < NUM_KEYS; j++) begin
                r_ldt[j] <= '0;
            end
        end else begin
            if (s_filt) begin
                r_axis <= n_axis;
            end
            if (s_dir) begin
                r_keys <= n_keys;
                r_idx  <= '0;
            end
            if (s_next) begin
                r_idx <= r_idx + 1'b1;
            end
            if (s_upd) begin
                r_rel[r_idx] <= !w_pressed;
                if (w_pressed && (w_cnt_new == HOLD_W'(1))) begin
                    r_ldt[r_idx] <= r_time;
                end
            end
        end
    end

    // hold counts, read only while the key is not released
    always_ff @(posedge i_clk) begin
        if (s_upd && w_pressed) begin
            r_cnt[r_idx] <= w_cnt_new;
        end
    end

    // pending and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if ((s_post && r_pend_v) || s_flush) begin
                r_out_v <= 1'b1;
            end else if (o_event.ready) begin
                r_out_v <= 1'b0;
            end
            if (s_post) begin
                r_pend_v <= 1'b1;
            end else if (s_flush) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((s_post && r_pend_v) || s_flush) begin
            r_out            <= r_pend;
            r_out.last_event <= s_flush;
        end
        if (s_post) begin
            r_pend.key_index  <= r_idx;
            r_pend.event_kind <= w_post_kind;
            r_pend.hold_ticks <= w_post_cnt;
            r_pend.last_event <= 1'b0;
        end
    end

    // shared remainder unit for the repeat test
    ked_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_rem_start),
        .i_dividend (w_cnt_new),
        .i_divisor  (r_rep),
        .o_valid    (w_rem_valid),
        .o_rem      (w_rem)
    );

    assign o_event.valid      = r_out_v;
    assign o_event.key_index  = r_out.key_index;
    assign o_event.event_kind = r_out.event_kind;
    assign o_event.hold_ticks = r_out.hold_ticks;
    assign o_event.last_event = r_out.last_event;

    // checks
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("pending event left over between ticks");

    a_walk_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK || r_state == ST_REM) |-> (r_idx <= KEY_LAST))
        else $error("key index out of range");

    a_rem_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_rem_start |=> (r_state == ST_REM) && !w_rem_valid)
        else $error("remainder start did not clear the old result");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_flush |=> r_out_v && r_out.last_event)
        else $error("final event of a tick not marked");

    a_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_enable) |=> (r_state == ST_IDLE))
        else $error("request taken while disabled changed state");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ked_pkg::*;

    localparam int AXIS_W         = 16;
    localparam int AXIS_FULL      = 16384;
    localparam int HOLD_LIMIT     = int'(HOLD_MAX);
    localparam int SETTLE_CYCLES  = 250;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int RUN_LIMIT      = 4_000_000;
    localparam int MAX_ERR_LINES  = 200;

    typedef struct {
        logic [BTN_W-1:0]         buttons;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] bx;
        logic signed [AXIS_W-1:0] by;
        logic [TIME_W-1:0]        now_ms;
    } t_tick;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ked_tick_if #(.AXIS_W(AXIS_W)) tick_bus ();
    ked_event_if                   event_bus ();

    key_event_detector_core #(
        .AXIS_WIDTH(AXIS_W)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_tick     (tick_bus),
        .o_event    (event_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // shadow registers of the detector
    logic              cfg_en;
    logic [THR_W-1:0]  cfg_press;
    logic [THR_W-1:0]  cfg_hold;
    logic [DC_W-1:0]   cfg_dc;
    logic [HOLD_W-1:0] cfg_long;
    logic [REP_W-1:0]  cfg_rep;

    // shadow key state
    logic signed [AXIS_W-1:0] axis_avg [NUM_AXES];
    logic [NUM_KEYS-1:0]      prev_keys;
    int                       hold_cnt [NUM_KEYS];
    logic [TIME_W-1:0]        down_stamp [NUM_KEYS];

    t_event pending_events [$];
    t_event head_ev;
    int     err_count;
    int     cycle_count;

    // sender pacing and stroke generator state
    int          gap_max;
    int          burst_left;
    int          hold_max;
    int          stroke_left;
    logic [1:0]  stroke_btn;
    int          stroke_axis [NUM_AXES];
    logic [31:0] clock_ms;
    bit          hold_off_req;

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_ERR_LINES) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    function automatic bit dir_hit(input bit was_set, input int value, input bit positive);
        int thr;
        thr = was_set ? int'(cfg_hold) : int'(cfg_press);
        return positive ? (value > thr) : (value < -thr);
    endfunction

    // filter, key decode and per-key events for one accepted tick
    task automatic predict_key_events(input t_tick t);
        logic signed [AXIS_W-1:0] samp [NUM_AXES];
        logic signed [AXIS_W:0]   sum;
        logic [NUM_KEYS-1:0]      keys;
        logic [TIME_W-1:0]        since_down;
        t_event                   batch [$];
        t_event                   ev;
        int                       i;
        int                       s;
        int                       k;
        int                       c;
        int                       base;
        int                       xv;
        int                       yv;
        bit                       advanced;
        bit                       fire;
        if (!cfg_en) return;
        samp[0] = t.ax;
        samp[1] = t.ay;
        samp[2] = t.bx;
        samp[3] = t.by;
        for (i = 0; i < NUM_AXES; i++) begin
            sum = {axis_avg[i][AXIS_W-1], axis_avg[i]} + {samp[i][AXIS_W-1], samp[i]};
            axis_avg[i] = sum[AXIS_W:1];
        end
        keys = '0;
        keys[BTN_W-1:0] = t.buttons;
        // direction keys with hysteresis on the previous status
        for (s = 0; s < 2; s++) begin
            base = 2 + 4 * s;
            xv = axis_avg[2 * s];
            yv = axis_avg[2 * s + 1];
            keys[base]     = dir_hit(prev_keys[base], xv, 1'b1);
            keys[base + 1] = dir_hit(prev_keys[base + 1], yv, 1'b1);
            keys[base + 2] = dir_hit(prev_keys[base + 2], xv, 1'b0);
            keys[base + 3] = dir_hit(prev_keys[base + 3], yv, 1'b0);
        end
        prev_keys = keys;
        // walk keys in fixed order
        for (k = 0; k < NUM_KEYS; k++) begin
            c = hold_cnt[k];
            fire = 1'b0;
            ev.event_kind = EV_DOWN;
            if (keys[k]) begin
                advanced = (c < HOLD_LIMIT);
                if (advanced) c++;
                hold_cnt[k] = c;
                if (c == 1) begin
                    since_down = t.now_ms - down_stamp[k];
                    ev.event_kind = (since_down < 32'(cfg_dc)) ? EV_DOUBLE : EV_DOWN;
                    down_stamp[k] = t.now_ms;
                    fire = 1'b1;
                end else if (c >= 2 && advanced && cfg_rep != 0 && c >= int'(cfg_long) &&
                             (c % int'(cfg_rep)) == 0) begin
                    ev.event_kind = EV_HELD;
                    fire = 1'b1;
                end
            end else begin
                if (c >= 1) begin
                    ev.event_kind = EV_UP;
                    fire = 1'b1;
                end
                hold_cnt[k] = -1;
            end
            if (fire) begin
                ev.key_index  = KEY_IDX_W'(k);
                ev.hold_ticks = HOLD_W'(c);
                ev.last_event = 1'b0;
                batch.push_back(ev);
            end
        end
        for (i = 0; i < batch.size(); i++) begin
            ev = batch[i];
            ev.last_event = (i == batch.size() - 1);
            pending_events.push_back(ev);
        end
    endtask

    // event checker
    always @(posedge clk) begin
        if (rst_n && event_bus.valid === 1'b1 && event_bus.ready === 1'b1) begin
            if (pending_events.size() == 0) begin
                flag_error($sformatf("unexpected event key %0d kind %0d hold %0d last %0b",
                    event_bus.key_index, event_bus.event_kind, event_bus.hold_ticks,
                    event_bus.last_event));
            end else begin
                head_ev = pending_events.pop_front();
                if (event_bus.key_index !== head_ev.key_index ||
                    event_bus.event_kind !== head_ev.event_kind ||
                    event_bus.hold_ticks !== head_ev.hold_ticks ||
                    event_bus.last_event !== head_ev.last_event) begin
                    flag_error($sformatf({"got key %0d kind %0d hold %0d last %0b, ",
                                          "want key %0d kind %0d hold %0d last %0b"},
                        event_bus.key_index, event_bus.event_kind, event_bus.hold_ticks,
                        event_bus.last_event, head_ev.key_index, head_ev.event_kind,
                        head_ev.hold_ticks, head_ev.last_event));
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int mode;
        int span;
        int rx_cycle;
        mode = 0;
        span = 0;
        rx_cycle = 0;
        event_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (hold_off_req) begin
                event_bus.ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
                hold_off_req = 1'b0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 160);
                end
                span--;
                case (mode)
                    0: event_bus.ready <= 1'b1;
                    1: event_bus.ready <= 1'($urandom_range(0, 1));
                    2: event_bus.ready <= (rx_cycle % 5) != 0;
                    default: event_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // one register write; the last of a group drops the write enable
    task automatic cfg_write(input t_cfg_idx idx, input int value, input bit last);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        case (idx)
            CFG_ENABLE:    cfg_en    = value[0];
            CFG_PRESS_THR: cfg_press = value[THR_W-1:0];
            CFG_HOLD_THR:  cfg_hold  = value[THR_W-1:0];
            CFG_DC_MS:     cfg_dc    = value[DC_W-1:0];
            CFG_LONG:      cfg_long  = value[HOLD_W-1:0];
            CFG_REPEAT:    cfg_rep   = value[REP_W-1:0];
            default: ;
        endcase
        if (last) begin
            cfg_we <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic apply_config(input bit en, input int press, input int hold, input int dc,
                                input int long_ticks, input int rep);
        cfg_write(CFG_PRESS_THR, press, 1'b0);
        cfg_write(CFG_HOLD_THR, hold, 1'b0);
        cfg_write(CFG_DC_MS, dc, 1'b0);
        cfg_write(CFG_LONG, long_ticks, 1'b0);
        cfg_write(CFG_REPEAT, rep, 1'b0);
        cfg_write(CFG_ENABLE, int'(en), 1'b1);
    endtask

    // drop the request and wait until every event has come and the block settles
    task automatic wait_idle();
        tick_bus.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // offer one tick request, then maybe a gap between bursts
    task automatic send_tick(input t_tick t);
        int gap;
        tick_bus.valid       <= 1'b1;
        tick_bus.button_bits <= t.buttons;
        tick_bus.stick_a_x   <= t.ax;
        tick_bus.stick_a_y   <= t.ay;
        tick_bus.stick_b_x   <= t.bx;
        tick_bus.stick_b_y   <= t.by;
        tick_bus.time_ms     <= t.now_ms;
        do @(posedge clk); while (tick_bus.ready !== 1'b1);
        predict_key_events(t);
        if (gap_max > 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, gap_max);
                tick_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    function automatic t_tick make_tick(input logic [1:0] b, input int xa, input int ya,
                                        input int xb, input int yb, input logic [31:0] ms);
        t_tick t;
        t.buttons = b;
        t.ax = AXIS_W'(xa);
        t.ay = AXIS_W'(ya);
        t.bx = AXIS_W'(xb);
        t.by = AXIS_W'(yb);
        t.now_ms = ms;
        return t;
    endfunction

    function automatic int rand_axis();
        return int'($urandom_range(0, 2 * AXIS_FULL)) - AXIS_FULL;
    endfunction

    function automatic int clamp_axis(input int v);
        if (v > AXIS_FULL) return AXIS_FULL;
        if (v < -AXIS_FULL) return -AXIS_FULL;
        return v;
    endfunction

    function automatic int pick_target();
        case ($urandom_range(0, 6))
            0, 1: return 0;
            2: return AXIS_FULL;
            3: return -AXIS_FULL;
            4: return int'($urandom_range(6000, 12000));
            5: return -int'($urandom_range(6000, 12000));
            default: return rand_axis();
        endcase
    endfunction

    // mostly held strokes with jitter, some glitches and pure noise
    task automatic gen_tick(output t_tick t);
        int r;
        int j;
        int a [NUM_AXES];
        r = $urandom_range(0, 99);
        if (r < 12) begin
            t = make_tick(2'($urandom), rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                          $urandom);
        end else begin
            if (stroke_left == 0) begin
                stroke_left = $urandom_range(1, hold_max);
                stroke_btn  = 2'($urandom);
                for (j = 0; j < NUM_AXES; j++) stroke_axis[j] = pick_target();
            end
            stroke_left--;
            for (j = 0; j < NUM_AXES; j++) begin
                a[j] = clamp_axis(stroke_axis[j] + int'($urandom_range(0, 800)) - 400);
            end
            case ($urandom_range(0, 9))
                0: clock_ms += $urandom_range(1, 60);
                1: clock_ms += $urandom_range(200, 400);
                default: clock_ms += 10;
            endcase
            t = make_tick((r < 20) ? 2'($urandom) : stroke_btn, a[0], a[1], a[2], a[3],
                          clock_ms);
        end
    endtask

    task automatic run_random(input int count);
        t_tick t;
        repeat (count) begin
            gen_tick(t);
            send_tick(t);
        end
    endtask

    // ticks while disabled are ignored, then the reset register values take over
    task automatic test_disabled_ticks();
        gap_max = 3;
        send_tick(make_tick(2'b11, AXIS_FULL, -AXIS_FULL, AXIS_FULL, -AXIS_FULL, 32'd100));
        send_tick(make_tick(2'b11, AXIS_FULL, -AXIS_FULL, AXIS_FULL, -AXIS_FULL, 32'd110));
        wait_idle();
        cfg_write(CFG_ENABLE, 1, 1'b1);
    endtask

    // down, up, double click and a one-tick glitch on the buttons
    task automatic test_button_clicks();
        logic [1:0] seq [8];
        int n;
        seq = '{2'b01, 2'b01, 2'b00, 2'b11, 2'b11, 2'b00, 2'b01, 2'b00};
        for (n = 0; n < 8; n++) begin
            send_tick(make_tick(seq[n], 0, 0, 0, 0, 32'(1000 + 10 * n)));
        end
    endtask

    // double click window across the time wrap
    task automatic test_time_wrap();
        send_tick(make_tick(2'b11, 0, 0, 0, 0, 32'hFFFF_FFF0));
        send_tick(make_tick(2'b11, 0, 0, 0, 0, 32'hFFFF_FFFA));
        send_tick(make_tick(2'b00, 0, 0, 0, 0, 32'd2));
        send_tick(make_tick(2'b11, 0, 0, 0, 0, 32'd4));
        send_tick(make_tick(2'b11, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_tick(make_tick(2'b00, 0, 0, 0, 0, 32'd8));
    endtask

    // full scale sticks both ways, then a held key kept by hysteresis
    task automatic test_stick_extremes();
        int n;
        for (n = 0; n < 3; n++) begin
            send_tick(make_tick(2'b10, AXIS_FULL, AXIS_FULL, -AXIS_FULL, -AXIS_FULL,
                                32'(5000 + 10 * n)));
        end
        for (n = 0; n < 3; n++) begin
            send_tick(make_tick(2'b01, -AXIS_FULL, -AXIS_FULL, AXIS_FULL, AXIS_FULL,
                                32'(5030 + 10 * n)));
        end
        send_tick(make_tick(2'b00, -2000, -2000, 2000, 2000, 32'd5060));
        send_tick(make_tick(2'b00, 0, 0, 0, 0, 32'd5070));
    endtask

    task automatic test_random_defaults();
        wait_idle();
        apply_config(1'b1, 9830, 6554, 300, 30, 10);
        gap_max = 6;
        hold_max = 45;
        clock_ms = $urandom;
        run_random(80);
    endtask

    task automatic test_random_low_extremes();
        wait_idle();
        apply_config(1'b1, 0, 0, 65535, 2, 1);
        gap_max = 6;
        hold_max = 12;
        run_random(60);
    endtask

    // disabled ticks leave state alone, then buttons only at high thresholds
    task automatic test_random_high_extremes();
        t_tick t;
        wait_idle();
        cfg_write(CFG_ENABLE, 0, 1'b1);
        repeat (5) begin
            gen_tick(t);
            send_tick(t);
        end
        wait_idle();
        apply_config(1'b1, AXIS_FULL, AXIS_FULL, 0, 5, 255);
        gap_max = 4;
        hold_max = 20;
        run_random(50);
    endtask

    task automatic test_random_config();
        wait_idle();
        apply_config(1'b1, $urandom_range(0, AXIS_FULL), $urandom_range(0, AXIS_FULL),
                     $urandom_range(0, 65535), $urandom_range(2, 12), $urandom_range(1, 6));
        gap_max = 8;
        hold_max = 30;
        run_random(30);
        wait_idle();
        apply_config(1'b1, $urandom_range(0, AXIS_FULL), $urandom_range(0, AXIS_FULL),
                     $urandom_range(0, 65535), $urandom_range(2, 40), $urandom_range(1, 255));
        gap_max = 0;
        run_random(30);
    endtask

    // repeat count of zero turns held presses off
    task automatic test_zero_repeat();
        wait_idle();
        apply_config(1'b1, 9830, 6554, 300, 2, 0);
        gap_max = 5;
        hold_max = 25;
        run_random(20);
    endtask

    // receiver holds off while ticks keep coming, so the block stalls its input
    task automatic test_output_backpressure();
        wait_idle();
        apply_config(1'b1, 0, 0, 65535, 2, 1);
        gap_max = 0;
        hold_max = 6;
        hold_off_req = 1'b1;
        run_random(20);
        wait_idle();
    endtask

    // one button held past the long press count, with periodic held presses
    task automatic test_long_hold();
        int n;
        wait_idle();
        apply_config(1'b1, 9830, 6554, 300, 4, 3);
        gap_max = 0;
        send_tick(make_tick(2'b00, 0, 0, 0, 0, clock_ms));
        for (n = 0; n < 12; n++) begin
            clock_ms += 10;
            send_tick(make_tick({1'($urandom_range(0, 1)), 1'b1}, 0, 0, 0, 0, clock_ms));
        end
        clock_ms += 10;
        send_tick(make_tick(2'b00, 0, 0, 0, 0, clock_ms));
    endtask

    // reset, tests in turn, final verdict
    initial begin
        int i;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_ENABLE;
        cfg_data             <= '0;
        tick_bus.valid       <= 1'b0;
        tick_bus.button_bits <= '0;
        tick_bus.stick_a_x   <= '0;
        tick_bus.stick_a_y   <= '0;
        tick_bus.stick_b_x   <= '0;
        tick_bus.stick_b_y   <= '0;
        tick_bus.time_ms     <= '0;
        cycle_count  = 0;
        err_count    = 0;
        gap_max      = 0;
        burst_left   = 0;
        hold_max     = 10;
        stroke_left  = 0;
        stroke_btn   = '0;
        clock_ms     = '0;
        hold_off_req = 1'b0;
        cfg_en       = 1'b0;
        cfg_press    = PRESS_THR_RST;
        cfg_hold     = HOLD_THR_RST;
        cfg_dc       = DC_MS_RST;
        cfg_long     = LONG_RST;
        cfg_rep      = REPEAT_RST;
        prev_keys    = '0;
        for (i = 0; i < NUM_AXES; i++) begin
            axis_avg[i]    = '0;
            stroke_axis[i] = 0;
        end
        for (i = 0; i < NUM_KEYS; i++) begin
            hold_cnt[i]   = -1;
            down_stamp[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_ticks();
        test_button_clicks();
        test_time_wrap();
        test_stick_extremes();
        test_random_defaults();
        test_random_low_extremes();
        test_random_high_extremes();
        test_random_config();
        test_zero_repeat();
        test_output_backpressure();
        test_long_hold();

        wait_idle();
        if (pending_events.size() != 0) begin
            flag_error($sformatf("%0d events never arrived", pending_events.size()));
        end
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
